// ===== rtl/assert_macros.svh =====
// assertion helpers used by base64_stream_encoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// types, constants and the sextet-to-ascii map of the base64 stream encoder
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'd61;
  localparam logic [7:0] PLUS_CHAR  = 8'd43;
  localparam logic [7:0] SLASH_CHAR = 8'd47;
  localparam logic [7:0] UPPER_BASE = 8'd65;
  localparam logic [7:0] LOWER_OFFS = 8'd71;
  localparam logic [7:0] DIGIT_OFFS = 8'd4;
  localparam logic [5:0] LAST_UPPER = 6'd25;
  localparam logic [5:0] LAST_LOWER = 6'd51;
  localparam logic [5:0] LAST_DIGIT = 6'd61;
  localparam logic [5:0] PLUS_CODE  = 6'd62;

  // one group of up to three bytes, msb first
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } grp_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] wide;
    wide = {2'b00, v};
    if (v <= LAST_UPPER) begin
      sextet_char = UPPER_BASE + wide;
    end else if (v <= LAST_LOWER) begin
      sextet_char = LOWER_OFFS + wide;
    end else if (v <= LAST_DIGIT) begin
      sextet_char = wide - DIGIT_OFFS;
    end else if (v == PLUS_CODE) begin
      sextet_char = PLUS_CHAR;
    end else begin
      sextet_char = SLASH_CHAR;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64e_if.sv =====
// ----------------------------------------------------------------------------
// b64e_if
// valid/ready channels for raw bytes in and base64 characters out
// ----------------------------------------------------------------------------
`default_nettype none

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// collects bytes into groups of up to three and pushes each full or final group
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
  input  wire logic           clk,
  input  wire logic           rst,
  b64e_byte_if.sink           in_ch,
  input  wire logic           full,
  output logic                push,
  output b64e_pkg::grp_t      push_grp
);

  logic [7:0] pb0;
  logic [7:0] pb1;
  logic [1:0] cnt;
  logic       store;
  logic       accept;

  // bytes that only get stored never need queue room
  assign store       = !in_ch.last_byte && (cnt < 2'd2);
  assign in_ch.ready = !full || store;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && !store;

  always_comb begin
    push_grp.last   = in_ch.last_byte;
    push_grp.nbytes = cnt + 2'd1;
    case (cnt)
      2'd0:    push_grp.bits = {in_ch.data_byte, 16'h0000};
      2'd1:    push_grp.bits = {pb0, in_ch.data_byte, 8'h00};
      default: push_grp.bits = {pb0, pb1, in_ch.data_byte};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      pb0 <= 8'h00;
      pb1 <= 8'h00;
    end else if (accept) begin
      if (store) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd0) begin
          pb0 <= in_ch.data_byte;
        end else begin
          pb1 <= in_ch.data_byte;
        end
      end else begin
        cnt <= 2'd0;
        pb0 <= 8'h00;
        pb1 <= 8'h00;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64e_fifo.sv =====
// ----------------------------------------------------------------------------
// b64e_fifo
// two-entry group queue between the byte side and the character side
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire b64e_pkg::grp_t push_grp,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output b64e_pkg::grp_t      head
);

  b64e_pkg::grp_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     level;
  logic           do_push;
  logic           do_pop;

  assign full       = (level == 2'd2);
  assign head_valid = (level != 2'd0);
  assign head       = slot[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// turns the head group into four characters, one per cycle unless out_ch
// stalls, into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire b64e_pkg::grp_t head,
  output logic                pop,
  b64e_char_if.source         out_ch
);

  logic [1:0] idx;
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_last;
  logic       load;
  logic [7:0] char_next;
  logic       last_next;

  assign load = head_valid && (!out_valid || out_ch.ready);
  assign pop  = load && (idx == 2'd3);

  always_comb begin
    last_next = 1'b0;
    case (idx)
      2'd0: char_next = b64e_pkg::sextet_char(head.bits[23:18]);
      2'd1: char_next = b64e_pkg::sextet_char(head.bits[17:12]);
      2'd2: begin
        char_next = (head.nbytes >= 2'd2) ? b64e_pkg::sextet_char(head.bits[11:6])
                                          : b64e_pkg::PAD_CHAR;
      end
      default: begin
        char_next = (head.nbytes == 2'd3) ? b64e_pkg::sextet_char(head.bits[5:0])
                                          : b64e_pkg::PAD_CHAR;
        last_next = head.last;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= idx + 2'd1;
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= char_next;
      out_last <= last_next;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_char  = out_char;
  assign out_ch.last_char = out_last;

endmodule

`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder, one byte in and one character out per request
//
// in_ch carries one message byte per request, last_byte set on the final
// byte. out_ch carries one ascii character per request, last_char set on
// the final character of the message, '=' pads included.
// bytes are taken one per cycle while the two-entry group queue has room;
// the first two bytes of a group are taken even with the queue full, unless
// one is the final byte. each full or final group becomes four characters,
// one per cycle while out_ch is ready, so the single-character output
// register sets the steady rate. with an empty queue the first character of
// a group passes through the queue slot and the output register to out_ch.
// reset clears the pending bytes, the queue and the output register; no
// character is presented in the cycle after reset.
// when out_ch stalls the output register holds, the queue fills and in_ch
// drops ready once a group needs a free slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module base64_stream_encoder (
  input  wire logic   clk,
  input  wire logic   rst,
  b64e_byte_if.sink   in_ch,
  b64e_char_if.source out_ch
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  b64e_pkg::grp_t q_in;
  b64e_pkg::grp_t q_head;

  b64e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .full     (q_full),
    .push     (q_push),
    .push_grp (q_in)
  );

  b64e_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_grp   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  `ASSERT_CLK_RST(a_no_push_full, clk, rst, q_push |-> !q_full, "group pushed into full queue")
  `ASSERT_CLK_RST(a_no_pop_empty, clk, rst, q_pop |-> q_valid, "group popped from empty queue")
  `ASSERT_CLK_RST(a_room_ready, clk, rst, !q_full |-> in_ch.ready, "input stalled with queue room")
  `ASSERT_CLK(a_quiet_reset, clk, $past(rst) |-> !out_ch.valid, "output valid right after reset")

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// base64 stream encoder testbench: bytes go in through a valid/ready channel
// with random gaps, every accepted byte runs through a local encoder model,
// and each character that leaves the block is checked in order against the
// characters that model predicts; directed messages cover pads, group
// boundaries and the extreme byte values, random messages and a long output
// stall follow
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned RANDOM_ITEMS   = 64;
  localparam int unsigned STALL_ITEMS    = 24;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst;

  b64e_byte_if byte_ch ();
  b64e_char_if char_ch ();

  base64_stream_encoder DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (byte_ch),
    .out_ch(char_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  enc_char_t   encoded_chars_q[$];
  enc_char_t   exp_char;
  logic [7:0]  held_bytes[2];
  int unsigned held_count;
  int unsigned err_count;
  int unsigned snd_max_gap;
  int unsigned rcv_max_gap;
  int unsigned chars_taken;
  int unsigned chars_seen;
  int unsigned hold_reqs;
  int unsigned holds_done;
  int unsigned rcv_wait;
  int unsigned idle_cycles;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return "A" + w;
    end else if (v < 6'd52) begin
      return "a" + w - 8'd26;
    end else if (v < 6'd62) begin
      return "0" + w - 8'd52;
    end else if (v == 6'd62) begin
      return "+";
    end
    return "/";
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic lst);
    enc_char_t c;
    c.ch  = ch;
    c.lst = lst;
    encoded_chars_q.push_back(c);
  endfunction

  // one accepted byte: store it, or close the group and queue four characters
  function automatic void encode_byte(input logic [7:0] b, input logic lst);
    logic [7:0]  grp[3];
    int unsigned n;
    if (!lst && held_count < 2) begin
      held_bytes[held_count] = b;
      held_count++;
      return;
    end
    grp[0] = held_bytes[0];
    grp[1] = held_bytes[1];
    grp[2] = 8'h00;
    grp[held_count] = b;
    n = held_count + 1;
    if (n < 2) grp[1] = 8'h00;
    push_char(b64_char(grp[0][7:2]), 1'b0);
    push_char(b64_char({grp[0][1:0], grp[1][7:4]}), 1'b0);
    push_char(n >= 2 ? b64_char({grp[1][3:0], grp[2][7:6]}) : b64e_pkg::PAD_CHAR, 1'b0);
    push_char(n >= 3 ? b64_char(grp[2][5:0]) : b64e_pkg::PAD_CHAR, lst);
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    held_count = 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_count = 0;
    end else if (byte_ch.valid && byte_ch.ready) begin
      encode_byte(byte_ch.data_byte, byte_ch.last_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst && char_ch.valid && char_ch.ready) begin
      chars_taken++;
      if (encoded_chars_q.size() == 0) begin
        $display("%0t unexpected char: expected none actual %02h last %0b",
                 $time, char_ch.out_char, char_ch.last_char);
        err_count++;
      end else begin
        exp_char = encoded_chars_q.pop_front();
        if (char_ch.out_char !== exp_char.ch) begin
          $display("%0t out_char mismatch: expected %02h actual %02h",
                   $time, exp_char.ch, char_ch.out_char);
          err_count++;
        end
        if (char_ch.last_char !== exp_char.lst) begin
          $display("%0t last_char mismatch: expected %0b actual %0b",
                   $time, exp_char.lst, char_ch.last_char);
          err_count++;
        end
      end
    end
  end

  // receiver: new wait after every character, or one long hold on request
  always @(negedge clk) begin
    if (hold_reqs != holds_done) begin
      holds_done = hold_reqs;
      rcv_wait = LONG_HOLD;
    end else if (chars_taken != chars_seen) begin
      chars_seen = chars_taken;
      rcv_wait = $urandom_range(0, rcv_max_gap);
    end
    if (rcv_wait > 0) begin
      char_ch.ready <= 1'b0;
      rcv_wait--;
    end else begin
      char_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = $urandom_range(0, snd_max_gap);
    @(negedge clk);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= lst;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  task automatic test_one_byte_messages();
    snd_max_gap = MAX_GAP;
    rcv_max_gap = MAX_GAP;
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_two_byte_messages();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_full_groups();
    snd_max_gap = 0;
    rcv_max_gap = 0;
    // plus and slash sextets, then a lone last byte after a full group
    send_byte(8'hfb, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'h5a, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_random_messages();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: begin
          snd_max_gap = 0;
          rcv_max_gap = 0;
        end
        1: begin
          snd_max_gap = MAX_GAP;
          rcv_max_gap = 0;
        end
        2: begin
          snd_max_gap = 0;
          rcv_max_gap = MAX_GAP;
        end
        default: begin
          snd_max_gap = MAX_GAP;
          rcv_max_gap = MAX_GAP;
        end
      endcase
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_output_stall();
    snd_max_gap = 0;
    rcv_max_gap = 0;
    hold_reqs++;
    for (int i = 0; i < STALL_ITEMS; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == STALL_ITEMS - 1);
    end
  endtask

  initial begin
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    char_ch.ready     = 1'b0;
    held_count        = 0;
    err_count         = 0;
    snd_max_gap       = 0;
    rcv_max_gap       = 0;
    chars_taken       = 0;
    chars_seen        = 0;
    hold_reqs         = 0;
    holds_done        = 0;
    rcv_wait          = 0;
    idle_cycles       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_one_byte_messages();
    test_two_byte_messages();
    test_full_groups();
    test_random_messages();
    test_output_stall();
    test_random_messages();

    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (encoded_chars_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
dv/tb_top.sv
